// File: rtl/htwd_pkg.sv
// shared constants, types and codes of the huffman tree-walk decoder
package htwd_pkg;

    localparam int NODE_DEPTH = 512;
    localparam int COUNT_BITS = 24;
    localparam int NODE_AW    = $clog2(NODE_DEPTH);
    localparam int IDX_W      = 9;
    localparam int SYM_W      = 8;
    localparam int CFG_W      = 24;
    localparam int BYTE_BITS  = 8;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 8;
    localparam int TYPE_W     = 2;

    localparam logic [2:0] LAST_BIT = 3'(BYTE_BITS - 1);

    localparam logic KIND_NODE = 1'b0;
    localparam logic KIND_BYTE = 1'b1;

    localparam logic [TYPE_W-1:0] RES_SYMBOL = 2'd0;
    localparam logic [TYPE_W-1:0] RES_OK     = 2'd1;
    localparam logic [TYPE_W-1:0] RES_BAD    = 2'd2;

    typedef struct packed {
        logic             leaf;
        logic [SYM_W-1:0] sym;
        logic [IDX_W-1:0] one;
        logic [IDX_W-1:0] zero;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    typedef struct packed {
        logic       take;
        logic       step;
        logic       flush;
        logic       status;
        logic [2:0] bit_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic is_byte;
        logic walk;
        logic leaf;
        logic hit;
        logic pend_valid;
        logic out_free;
        logic fin;
    } dp_stat_t;

endpackage

// File: rtl/htwd_ram.sv
// generic single write port ram with registered read
module htwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/htwd_datapath.sv
// datapath of the decoder: node memory, walk registers, counters and output register
module htwd_datapath
    import htwd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_W-1:0]      cfg_wr_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [TYPE_W-1:0]     m_tuser,
    output logic                  m_tlast
);

    logic [CFG_W-1:0]      symbol_total_reg;
    logic [COUNT_BITS-1:0] symbols_done_reg, symbols_done_next;
    logic [IDX_W-1:0]      current_reg, current_next;
    logic                  fin_in_reg, fin_in_next;
    logic                  fin_before_reg, fin_before_next;
    logic                  ok_start_reg, ok_start_next;
    logic                  ok_inside_reg, ok_inside_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    node_t                 cur_reg, cur_next;
    node_t                 root_reg, root_next;
    logic [SYM_W-1:0]      pend_sym_reg, pend_sym_next;
    logic [BYTE_BITS-1:0]  byte_reg;
    logic                  fin_reg;
    logic                  oob_reg;
    logic [IDX_W-1:0]      issued_reg;
    logic [SYM_W-1:0]      m_sym_reg;
    logic [TYPE_W-1:0]     m_type_reg;
    logic                  m_last_reg;

    logic [IDX_W-1:0]            wr_idx;
    node_t                       wr_node;
    logic [BYTE_BITS-1:0]        in_byte;
    logic                        idx_ok;
    logic [CFG_W+COUNT_BITS-1:0] total_ext;
    logic [COUNT_BITS-1:0]       total;
    logic [COUNT_BITS-1:0]       cnt_inc;
    logic                        hit;
    logic                        done_pre;
    logic                        skip;
    logic                        ram_we;
    logic                        ram_re;
    logic [NODE_W-1:0]           rd_raw;
    node_t                       nx;
    node_t                       base;
    logic [IDX_W-1:0]            child;
    logic                        child_oob;
    logic                        out_free;
    logic                        push;
    logic [SYM_W-1:0]            push_sym;
    logic [TYPE_W-1:0]           push_type;
    logic                        push_last;

    assign wr_idx       = s_tdata[8:0];
    assign wr_node.leaf = s_tdata[9];
    assign wr_node.sym  = s_tdata[17:10];
    assign wr_node.one  = s_tdata[26:18];
    assign wr_node.zero = s_tdata[35:27];
    assign in_byte      = s_tdata[43:36];

    assign idx_ok    = (IDX_W+1)'(wr_idx) < (IDX_W+1)'(NODE_DEPTH);
    assign total_ext = {{COUNT_BITS{1'b0}}, symbol_total_reg};
    assign total     = total_ext[COUNT_BITS-1:0];
    assign cnt_inc   = symbols_done_reg + COUNT_BITS'(1);
    assign hit       = cnt_inc >= total;
    assign done_pre  = !fin_in_reg && !fin_before_reg && (symbols_done_reg >= total);
    assign skip      = fin_before_reg || done_pre || fin_in_reg;
    assign nx        = oob_reg ? node_t'('0) : node_t'(rd_raw);
    assign out_free  = !m_tvalid_reg || m_tready;

    assign ram_we = cmd.take && (s_tuser == KIND_NODE) && idx_ok;

    htwd_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_DEPTH)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_idx[NODE_AW-1:0]),
        .wdata (wr_node),
        .re    (ram_re),
        .raddr (child[NODE_AW-1:0]),
        .rdata (rd_raw)
    );

    // next child address for the read of the following bit
    always_comb begin
        base   = nx.leaf ? root_reg : nx;
        child  = '0;
        ram_re = 1'b0;
        if (cmd.take) begin
            child  = in_byte[BYTE_BITS-1] ? cur_reg.one : cur_reg.zero;
            ram_re = (s_tuser == KIND_BYTE) && !skip;
        end else if (cmd.step) begin
            child  = byte_reg[3'd6 - cmd.bit_sel] ? base.one : base.zero;
            ram_re = (cmd.bit_sel != LAST_BIT) && !(nx.leaf && hit);
        end
        child_oob = (IDX_W+1)'(child) >= (IDX_W+1)'(NODE_DEPTH);
    end

    always_comb begin
        push      = 1'b0;
        push_sym  = pend_sym_reg;
        push_type = RES_SYMBOL;
        push_last = 1'b0;
        if (cmd.status) begin
            push      = 1'b1;
            push_sym  = '0;
            push_type = (ok_start_reg || ok_inside_reg) ? RES_OK : RES_BAD;
            push_last = 1'b1;
        end else if (cmd.flush) begin
            push      = pend_valid_reg;
            push_last = !fin_reg;
        end else if (cmd.step && nx.leaf) begin
            push      = pend_valid_reg;
        end
    end

    always_comb begin
        symbols_done_next = symbols_done_reg;
        current_next      = current_reg;
        fin_in_next       = fin_in_reg;
        fin_before_next   = fin_before_reg;
        ok_start_next     = ok_start_reg;
        ok_inside_next    = ok_inside_reg;
        pend_valid_next   = pend_valid_reg;
        pend_sym_next     = pend_sym_reg;
        cur_next          = cur_reg;
        root_next         = root_reg;
        m_tvalid_next     = push ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

        if (cmd.take) begin
            if (s_tuser == KIND_NODE) begin
                if (idx_ok && (wr_idx == '0)) begin
                    root_next = wr_node;
                end
                if (idx_ok && (wr_idx == current_reg)) begin
                    cur_next = wr_node;
                end
            end else begin
                ok_inside_next = 1'b0;
                ok_start_next  = fin_before_reg || done_pre;
                if (fin_before_reg || done_pre) begin
                    fin_before_next = 1'b0;
                    fin_in_next     = 1'b1;
                end
            end
        end

        if (cmd.step) begin
            if (nx.leaf) begin
                pend_valid_next   = 1'b1;
                pend_sym_next     = nx.sym;
                symbols_done_next = cnt_inc;
                current_next      = '0;
                cur_next          = root_reg;
                if (hit) begin
                    if (cmd.bit_sel != LAST_BIT) begin
                        fin_in_next    = 1'b1;
                        ok_inside_next = 1'b1;
                    end else begin
                        fin_before_next = 1'b1;
                    end
                end
            end else begin
                current_next = issued_reg;
                cur_next     = nx;
            end
        end

        if (cmd.flush) begin
            pend_valid_next = 1'b0;
        end

        if (cmd.status) begin
            symbols_done_next = '0;
            current_next      = '0;
            cur_next          = root_reg;
            fin_in_next       = 1'b0;
            fin_before_next   = 1'b0;
            ok_start_next     = 1'b0;
            ok_inside_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            symbol_total_reg <= '0;
            symbols_done_reg <= '0;
            current_reg      <= '0;
            fin_in_reg       <= 1'b0;
            fin_before_reg   <= 1'b0;
            ok_start_reg     <= 1'b0;
            ok_inside_reg    <= 1'b0;
            pend_valid_reg   <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                symbol_total_reg <= cfg_wr_data;
            end
            symbols_done_reg <= symbols_done_next;
            current_reg      <= current_next;
            fin_in_reg       <= fin_in_next;
            fin_before_reg   <= fin_before_next;
            ok_start_reg     <= ok_start_next;
            ok_inside_reg    <= ok_inside_next;
            pend_valid_reg   <= pend_valid_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        root_reg     <= root_next;
        pend_sym_reg <= pend_sym_next;
        if (cmd.take) begin
            byte_reg <= in_byte;
            fin_reg  <= s_tlast;
        end
        if (ram_re) begin
            oob_reg    <= child_oob;
            issued_reg <= child;
        end
        if (push) begin
            m_sym_reg  <= push_sym;
            m_type_reg <= push_type;
            m_last_reg <= push_last;
        end
    end

    assign stat.is_byte    = (s_tuser == KIND_BYTE);
    assign stat.walk       = !skip;
    assign stat.leaf       = nx.leaf;
    assign stat.hit        = hit;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = out_free;
    assign stat.fin        = fin_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_sym_reg;
    assign m_tuser  = m_type_reg;
    assign m_tlast  = m_last_reg;

endmodule

// File: rtl/htwd_ctrl.sv
// controller state machine sequencing the bit walk and result delivery
module htwd_ctrl
    import htwd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_END    = 2'd2;
    localparam logic [1:0] ST_STATUS = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [2:0] bit_reg, bit_next;

    always_comb begin
        state_next  = state_reg;
        bit_next    = bit_reg;
        cmd         = '0;
        cmd.bit_sel = bit_reg;
        s_tready    = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.take = 1'b1;
                    if (stat.is_byte) begin
                        bit_next   = '0;
                        state_next = stat.walk ? ST_WALK : ST_END;
                    end
                end
            end
            ST_WALK: begin
                if (!stat.leaf || !stat.pend_valid || stat.out_free) begin
                    cmd.step = 1'b1;
                    if ((stat.leaf && stat.hit) || (bit_reg == LAST_BIT)) begin
                        state_next = ST_END;
                    end else begin
                        bit_next = bit_reg + 3'd1;
                    end
                end
            end
            ST_END: begin
                if (!stat.pend_valid || stat.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = stat.fin ? ST_STATUS : ST_IDLE;
                end
            end
            ST_STATUS: begin
                if (stat.out_free) begin
                    cmd.status = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            bit_reg   <= '0;
        end else begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
        end
    end

endmodule

// File: rtl/huffman_tree_walk_decoder_top.sv
// top level of the huffman tree-walk decoder
//
// input stream: s_tuser = 0 writes one tree node (root at address 0), s_tuser = 1
// carries a compressed byte, read msb first; s_tlast marks the last byte of a message.
// symbol_total is written through cfg_wr_en / cfg_wr_data while the block is idle.
// output stream: m_tuser 0 = decoded symbol in m_tdata, 1 = message ended correctly,
// 2 = message invalid; m_tlast marks the last result caused by one input transaction.
// a node write is accepted directly. a compressed byte is accepted and then walked
// bit by bit, up to eight bits, each bit being one read of the node memory, then the
// byte is closed and, for a final byte, the status result is sent. a byte after
// decoding completed skips the walk. a decoded symbol is held back until the next
// symbol or the close of its byte so that its last flag is known, and results leave
// through a single output register.
// when the receiver stalls, the walk waits on the next symbol that needs the output
// register; no result is dropped and s_tready stays low meanwhile.
// reset (aresetn low, synchronous) returns the walk to the root, clears the counters
// and symbol_total; node memory contents are undefined until written.
module huffman_tree_walk_decoder_top
    import htwd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // node_index[8:0], node_is_leaf[9], node_symbol[17:10], one_child[26:18],
    // zero_child[35:27], data_byte[43:36], zero[47:44]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // kind[0]
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_W-1:0]      cfg_wr_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // symbol[7:0]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // result_type[1:0]
    output logic [TYPE_W-1:0]     m_tuser,
    output logic                  m_tlast
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    htwd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    htwd_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// File: tb/tb.sv
// self-checking testbench of the huffman tree-walk decoder: directed walks, then random messages
module tb
    import htwd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_LSB      = 36;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int MSG_MAX_BYTES = 12;

    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic [TYPE_W-1:0] rtype;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [IDX_W-1:0]      node;
        logic [COUNT_BITS-1:0] count;
        logic                  fin_in;
        logic                  fin_before;
        logic                  ok;
    } walk_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  s_tlast;
    logic                  cfg_wr_en;
    logic [CFG_W-1:0]      cfg_wr_data;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [TYPE_W-1:0]     m_tuser;
    logic                  m_tlast;

    node_t         tree_mem [NODE_DEPTH];
    bit            node_written [NODE_DEPTH];
    int            written_list [$];
    walk_t         walk_st;
    logic [CFG_W-1:0] total_reg;
    result_t       due_results [$];

    int src_idle_pct;
    int sink_stall_pct;
    int items_sent;
    int results_seen;
    int mismatches;
    int cycles;

    huffman_tree_walk_decoder_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycles,
                     due_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // walks one byte through the code tree; results go to the due queue only on commit
    function automatic walk_t walk_byte(input walk_t st, input logic [7:0] b,
                                        input logic fin, input bit commit);
        result_t          got [$];
        result_t          entry;
        node_t            cur;
        node_t            nxt;
        logic [IDX_W-1:0] child;
        logic             ok_start;
        logic             ok_inside;
        bit               stop;
        int               k;
        ok_inside = 1'b0;
        stop = 1'b0;
        st.ok = 1'b0;
        // completion already reached before this byte
        if (!st.fin_in && !st.fin_before && st.count >= total_reg[COUNT_BITS-1:0])
            st.fin_before = 1'b1;
        ok_start = st.fin_before;
        if (st.fin_before) begin
            st.fin_before = 1'b0;
            st.fin_in = 1'b1;
        end else if (!st.fin_in) begin
            k = 0;
            while (k < BYTE_BITS && !stop) begin
                cur = tree_mem[st.node];
                child = b[BYTE_BITS-1-k] ? cur.one : cur.zero;
                nxt = tree_mem[child];
                st.node = child;
                if (nxt.leaf) begin
                    entry = '{sym: nxt.sym, rtype: RES_SYMBOL, last: 1'b0};
                    got.insert(got.size(), entry);
                    st.node = '0;
                    st.count = st.count + 1'b1;
                    if (st.count >= total_reg[COUNT_BITS-1:0]) begin
                        if (k < int'(LAST_BIT)) begin
                            st.fin_in = 1'b1;
                            ok_inside = 1'b1;
                        end else begin
                            st.fin_before = 1'b1;
                        end
                        stop = 1'b1;
                    end
                end
                k++;
            end
        end
        if (fin) begin
            st.ok = ok_start | ok_inside;
            entry = '{sym: '0, rtype: (st.ok ? RES_OK : RES_BAD), last: 1'b0};
            got.insert(got.size(), entry);
            st.node = '0;
            st.count = '0;
            st.fin_in = 1'b0;
            st.fin_before = 1'b0;
        end
        if (got.size() > 0)
            got[got.size()-1].last = 1'b1;
        if (commit) begin
            foreach (got[i])
                due_results.insert(due_results.size(), got[i]);
        end
        return st;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_node(input int idx, input logic leaf,
                                                       input logic [SYM_W-1:0] sym,
                                                       input int one, input int zero);
        return {4'b0, 8'($urandom), 9'(zero), 9'(one), sym, leaf, 9'(idx)};
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_byte(input logic [7:0] b);
        return {4'b0, b, 36'({$urandom, $urandom})};
    endfunction

    function automatic int pick_written();
        return written_list[$urandom_range(written_list.size() - 1)];
    endfunction

    function automatic logic [CFG_W-1:0] pick_total();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        else if (r < 16)
            return CFG_W'($urandom);
        return CFG_W'($urandom_range(8, 1));
    endfunction

    task automatic send_item(input logic kind, input logic [IN_DATA_W-1:0] data,
                             input logic fin);
        int idx;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = kind;
        s_tdata = data;
        s_tlast = fin;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
        if (kind == KIND_NODE) begin
            idx = int'(data[8:0]);
            tree_mem[idx].leaf = data[9];
            tree_mem[idx].sym  = data[17:10];
            tree_mem[idx].one  = data[26:18];
            tree_mem[idx].zero = data[35:27];
            if (!node_written[idx]) begin
                node_written[idx] = 1'b1;
                written_list.insert(written_list.size(), idx);
            end
        end else begin
            walk_st = walk_byte(walk_st, data[BYTE_LSB+7:BYTE_LSB], fin, 1'b1);
        end
        @(negedge aclk);
    endtask

    task automatic write_node(input int idx, input logic leaf, input logic [SYM_W-1:0] sym,
                              input int one, input int zero);
        send_item(KIND_NODE, pack_node(idx, leaf, sym, one, zero), 1'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        send_item(KIND_BYTE, pack_byte(b), fin);
    endtask

    // wait until every due result has arrived and the walk has had time to finish
    task automatic settle();
        s_tvalid = 1'b0;
        while (due_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_total(input logic [CFG_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        total_reg = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // random full tree, leaves first so that every child is written before its parent
    task automatic build_random_tree(input int n_leaves);
        int addrs [$];
        int pool [$];
        int a;
        int i;
        int x;
        int y;
        int dst;
        int next_int;
        bit dup;
        while (addrs.size() < 2 * n_leaves - 2) begin
            a = $urandom_range(NODE_DEPTH - 1, 1);
            dup = 1'b0;
            foreach (addrs[q])
                if (addrs[q] == a)
                    dup = 1'b1;
            if (!dup)
                addrs.insert(addrs.size(), a);
        end
        for (i = 0; i < n_leaves; i++) begin
            write_node(addrs[i], 1'b1, 8'($urandom), $urandom_range(NODE_DEPTH - 1),
                       $urandom_range(NODE_DEPTH - 1));
            pool.insert(pool.size(), addrs[i]);
        end
        next_int = n_leaves;
        while (pool.size() > 1) begin
            i = $urandom_range(pool.size() - 1);
            x = pool[i];
            pool.delete(i);
            i = $urandom_range(pool.size() - 1);
            y = pool[i];
            pool.delete(i);
            if (pool.size() == 0) begin
                dst = 0;
            end else begin
                dst = addrs[next_int];
                next_int++;
            end
            write_node(dst, 1'b0, 8'($urandom), x, y);
            pool.insert(pool.size(), dst);
        end
    endtask

    // well-formed: the final byte is the one in which decoding completes, or the twelfth byte
    task automatic send_message(input bit well_formed);
        walk_t      trial;
        logic [7:0] b;
        int         n;
        int         n_bytes;
        bit         closed;
        if (well_formed) begin
            n = 0;
            closed = 1'b0;
            while (!closed) begin
                b = 8'($urandom);
                trial = walk_byte(walk_st, b, 1'b1, 1'b0);
                closed = trial.ok || (n == MSG_MAX_BYTES - 1);
                send_byte(b, closed);
                n++;
            end
        end else begin
            n_bytes = $urandom_range(4, 1);
            for (n = 0; n < n_bytes; n++)
                send_byte(8'($urandom), n == n_bytes - 1);
        end
    endtask

    // small tree with codes 0, 10 and 11 0* 1, so a byte can end without a symbol
    task automatic test_directed_cases();
        write_node(511,   1'b1, 8'h00, 0, 0);
        write_node(9'h0AA, 1'b1, 8'hFF, 511, 511);
        write_node(9'h02B, 1'b1, 8'h5A, 0, 0);
        write_node(9'h155, 1'b0, 8'h00, 9'h02B, 9'h155);
        write_node(9'h100, 1'b0, 8'hFF, 9'h155, 9'h0AA);
        write_node(0,     1'b0, 8'h00, 9'h100, 511);
        // symbol total still at its reset value of zero
        send_byte(8'hFF, 1'b1);
        settle();
        write_total(CFG_W'(4));
        send_byte(8'h00, 1'b1);
        // completion on the last bit of a byte, then a final byte
        send_byte(8'hAA, 1'b0);
        send_byte(8'h00, 1'b1);
        // completion on the last bit of the final byte
        send_byte(8'hAA, 1'b1);
        // a byte with no symbol, completion in a later byte, then trailing bits
        send_byte(8'hC0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h00, 1'b1);
        settle();
        write_total(CFG_W'(9));
        send_byte(8'h55, 1'b1);
        // total lowered mid-message below the symbols already decoded
        send_byte(8'h00, 1'b0);
        settle();
        write_total(CFG_W'(3));
        send_byte(8'hFF, 1'b1);
        settle();
        write_total('1);
        send_byte(8'h00, 1'b1);
    endtask

    // a leaf at the root is never emitted, only the nodes it steps to
    task automatic test_root_leaf();
        write_node(0, 1'b1, 8'h3C, 9'h02B, 511);
        send_byte(8'hF0, 1'b1);
        write_node(0, 1'b0, 8'h00, 9'h100, 511);
    endtask

    task automatic test_random_messages(input int src_pct, input int sink_pct);
        int blk;
        int start;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        for (blk = 0; blk < 3; blk++) begin
            settle();
            write_total(pick_total());
            start = items_sent;
            if (blk == 0 || $urandom_range(1) == 1)
                build_random_tree($urandom_range(8, 2));
            while (items_sent - start < 20) begin
                if ($urandom_range(99) < 6)
                    write_node($urandom_range(NODE_DEPTH - 1), 1'($urandom), 8'($urandom),
                               pick_written(), pick_written());
                send_message($urandom_range(99) < 75);
            end
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: symbol %h type %0d last %b",
                             m_tdata, m_tuser, m_tlast);
            end else begin
                want = due_results.pop_front();
                if (m_tdata !== want.sym || m_tuser !== want.rtype || m_tlast !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected symbol %h type %0d last %b, %s %h %0d %b",
                                 results_seen, want.sym, want.rtype, want.last,
                                 "got", m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        items_sent = 0;
        walk_st = '0;
        total_reg = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed_cases();
        test_root_leaf();
        test_random_messages(0, 0);
        test_random_messages(74, 0);
        test_random_messages(0, 74);
        test_random_messages(32, 32);
        settle();
        $display("%0d input transactions sent, %0d results checked", items_sent, results_seen);
        $display("covered tree loads, early and late completion, short messages and idling");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/htwd_pkg.sv
rtl/htwd_ram.sv
rtl/htwd_datapath.sv
rtl/htwd_ctrl.sv
rtl/huffman_tree_walk_decoder_top.sv
tb/tb.sv
